// File: rtl/multitap_keypad_text_entry_defines.svh
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MKTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mkte checker: property failed");

// Next-cycle implication, disabled while reset is asserted
`define MKTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mkte checker: property failed");

`endif

// File: rtl/mkte_pkg.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: package
// Codes, state and result types, and the key group character tables.
// ----------------------------------------------------------------------------
package mkte_pkg;

    // Largest text the block tracks; the length counter is 8 bits wide
    localparam int MAX_TEXT = 255;
    localparam logic [7:0] TEXT_CAP = 8'((MAX_TEXT > 255) ? 255 : MAX_TEXT);

    localparam int NUM_GROUPS = 10;
    localparam logic [3:0] NO_GROUP = 4'hF;

    localparam logic [7:0]  MAX_LENGTH_RESET = 8'd255;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd500;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    localparam logic REG_MAX_LENGTH    = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        CMD_TAP       = 2'd0,
        CMD_HOLD      = 2'd1,
        CMD_BACKSPACE = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_APPEND  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_DELETE  = 2'd3
    } edit_op_t;

    typedef struct packed {
        logic [3:0]  current_group;
        logic [3:0]  tap_index;
        logic        tap_pending;
        logic [15:0] idle_ticks;
        logic [7:0]  length_count;
    } mkte_state_t;

    typedef struct packed {
        edit_op_t   edit_op;
        logic [6:0] char_code;
        logic [7:0] text_length;
        logic       became_empty;
        logic       rejected;
    } mkte_result_t;

    // Number of characters on a key group
    function automatic logic [3:0] group_len(input logic [3:0] grp);
        logic [3:0] n;
        case (grp)
            4'd0:    n = 4'd10;
            4'd6:    n = 4'd5;
            4'd8:    n = 4'd5;
            4'd9:    n = 4'd2;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

    // Character at position idx of a key group's cycle
    function automatic logic [6:0] group_char(input logic [3:0] grp, input logic [3:0] idx);
        logic [7:0] c;
        c = 8'd0;
        case (grp)
            4'd0: begin
                case (idx)
                    4'd0:    c = ".";
                    4'd1:    c = ",";
                    4'd2:    c = "?";
                    4'd3:    c = "!";
                    4'd4:    c = "-";
                    4'd5:    c = ":";
                    4'd6:    c = "(";
                    4'd7:    c = ")";
                    4'd8:    c = "*";
                    4'd9:    c = "1";
                    default: c = 8'd0;
                endcase
            end
            4'd1: begin
                case (idx)
                    4'd0: c = "a";  4'd1: c = "b";  4'd2: c = "c";  4'd3: c = "2";
                    default: c = 8'd0;
                endcase
            end
            4'd2: begin
                case (idx)
                    4'd0: c = "d";  4'd1: c = "e";  4'd2: c = "f";  4'd3: c = "3";
                    default: c = 8'd0;
                endcase
            end
            4'd3: begin
                case (idx)
                    4'd0: c = "g";  4'd1: c = "h";  4'd2: c = "i";  4'd3: c = "4";
                    default: c = 8'd0;
                endcase
            end
            4'd4: begin
                case (idx)
                    4'd0: c = "j";  4'd1: c = "k";  4'd2: c = "l";  4'd3: c = "5";
                    default: c = 8'd0;
                endcase
            end
            4'd5: begin
                case (idx)
                    4'd0: c = "m";  4'd1: c = "n";  4'd2: c = "o";  4'd3: c = "6";
                    default: c = 8'd0;
                endcase
            end
            4'd6: begin
                case (idx)
                    4'd0: c = "p";  4'd1: c = "q";  4'd2: c = "r";  4'd3: c = "s";
                    4'd4: c = "7";
                    default: c = 8'd0;
                endcase
            end
            4'd7: begin
                case (idx)
                    4'd0: c = "t";  4'd1: c = "u";  4'd2: c = "v";  4'd3: c = "8";
                    default: c = 8'd0;
                endcase
            end
            4'd8: begin
                case (idx)
                    4'd0: c = "w";  4'd1: c = "x";  4'd2: c = "y";  4'd3: c = "z";
                    4'd4: c = "9";
                    default: c = 8'd0;
                endcase
            end
            4'd9: begin
                case (idx)
                    4'd0:    c = " ";
                    4'd1:    c = "0";
                    default: c = 8'd0;
                endcase
            end
            default: c = 8'd0;
        endcase
        return c[6:0];
    endfunction

endpackage

// File: rtl/mkte_step.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: update logic
// Computes the next entry state and the result for one request.
// ----------------------------------------------------------------------------
module mkte_step
    import mkte_pkg::*;
(
    input  mkte_state_t  cur,
    input  logic [1:0]   cmd,
    input  logic [3:0]   key_group,
    input  logic [7:0]   max_length,
    input  logic [15:0]  timeout_ticks,
    output mkte_state_t  nxt,
    output mkte_result_t res
);

    logic [7:0]  cap;
    logic        grp_ok;
    logic        same_grp;
    logic [3:0]  len;
    logic [3:0]  idx_inc;
    logic [3:0]  idx_wrap;
    logic [15:0] idle_inc;

    // Effective length limit and cycling index
    assign cap      = (max_length < TEXT_CAP) ? max_length : TEXT_CAP;
    assign grp_ok   = (key_group < 4'(NUM_GROUPS));
    assign same_grp = (key_group == cur.current_group);
    assign len      = group_len(key_group);
    assign idx_inc  = cur.tap_index + 4'd1;
    assign idx_wrap = (idx_inc >= len) ? 4'd0 : idx_inc;
    assign idle_inc = (cur.idle_ticks == 16'hFFFF) ? cur.idle_ticks
                                                   : cur.idle_ticks + 16'd1;

    // Decode the command and update state
    always_comb begin
        nxt              = cur;
        res.edit_op      = OP_NONE;
        res.char_code    = 7'd0;
        res.became_empty = 1'b0;
        res.rejected     = 1'b0;
        case (cmd_t'(cmd))
            CMD_TAP: begin
                if (cur.length_count >= cap) begin
                    res.rejected = 1'b1;
                end else if (grp_ok) begin
                    if (same_grp && cur.tap_pending && (cur.length_count != 8'd0)) begin
                        nxt.tap_index = idx_wrap;
                        res.edit_op   = OP_REPLACE;
                        res.char_code = group_char(key_group, idx_wrap);
                    end else begin
                        nxt.current_group = key_group;
                        nxt.tap_index     = 4'd0;
                        nxt.length_count  = cur.length_count + 8'd1;
                        res.edit_op       = OP_APPEND;
                        res.char_code     = group_char(key_group, 4'd0);
                    end
                    nxt.tap_pending = 1'b1;
                    nxt.idle_ticks  = 16'd0;
                end
            end
            CMD_HOLD: begin
                if (grp_ok && same_grp) begin
                    if (cur.length_count != 8'd0) begin
                        res.edit_op   = OP_REPLACE;
                        res.char_code = group_char(key_group, len - 4'd1);
                    end
                    nxt.tap_pending = 1'b0;
                    nxt.idle_ticks  = 16'd0;
                end
            end
            CMD_BACKSPACE: begin
                if (cur.length_count != 8'd0) begin
                    nxt.length_count = cur.length_count - 8'd1;
                    res.edit_op      = OP_DELETE;
                    res.became_empty = (cur.length_count == 8'd1);
                end
            end
            CMD_TICK: begin
                if (cur.tap_pending) begin
                    if (idle_inc >= timeout_ticks) begin
                        nxt.tap_pending = 1'b0;
                        nxt.idle_ticks  = 16'd0;
                    end else begin
                        nxt.idle_ticks = idle_inc;
                    end
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        res.text_length = nxt.length_count;
    end

endmodule

// File: rtl/multitap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: top level
// Phone keypad multi-tap editor that tracks text length and edit operations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: a tap, hold, backspace or tick with its
//   key group. Each request gives exactly one result on the m_ stream: the
//   edit to apply to the text, the character, the new length and flags.
//   A request is registered on acceptance and the state update runs as it
//   moves into the result register. Throughput is one request per cycle
//   while the receiver takes each result; the single update path runs from
//   the input register to the result register.
//   When the receiver stalls, the result register holds and the input
//   register takes one more request; s_tready then drops until the result
//   is taken.
//   Reset empties both registers, clears the text state (no group, nothing
//   pending, length 0) and sets max_length to 255 and timeout_ticks to 500.
//   The cfg_ port writes a register while cfg_we is high; write it only while idle.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry
    import mkte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] cmd, [5:2] key_group

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] edit_op, [8:2] char_code, [16:9] text_length,
    // [17] became_empty, [18] rejected
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [15:0]           cfg_wdata
);

    logic         in_valid_reg, in_valid_next;
    logic [1:0]   in_cmd_reg;
    logic [3:0]   in_group_reg;
    mkte_state_t  state_reg, state_next;
    logic [7:0]   max_length_reg;
    logic [15:0]  timeout_ticks_reg;
    logic         out_valid_reg, out_valid_next;
    mkte_result_t out_res_reg;
    mkte_result_t step_res;
    logic         s_fire;
    logic         advance;

    // Move the held request into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    mkte_step u_step (
        .cur           (state_reg),
        .cmd           (in_cmd_reg),
        .key_group     (in_group_reg),
        .max_length    (max_length_reg),
        .timeout_ticks (timeout_ticks_reg),
        .nxt           (state_next),
        .res           (step_res)
    );

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.current_group <= NO_GROUP;
            state_reg.tap_index     <= 4'd0;
            state_reg.tap_pending   <= 1'b0;
            state_reg.idle_ticks    <= 16'd0;
            state_reg.length_count  <= 8'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg    <= MAX_LENGTH_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MAX_LENGTH:    max_length_reg    <= cfg_wdata[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default:           max_length_reg    <= max_length_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= s_tdata[1:0];
            in_group_reg <= s_tdata[5:2];
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_res_reg.rejected,
                       out_res_reg.became_empty,
                       out_res_reg.text_length,
                       out_res_reg.char_code,
                       out_res_reg.edit_op};

endmodule

// File: rtl/mkte_checker.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: port checker
// Watches the result stream for consistent edit results over time.
// ----------------------------------------------------------------------------
`include "multitap_keypad_text_entry_defines.svh"

module mkte_checker
    import mkte_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [1:0] op;
    logic [6:0] ch;
    logic [7:0] len;
    logic       empt;
    logic       rej;

    assign op   = m_tdata[1:0];
    assign ch   = m_tdata[8:2];
    assign len  = m_tdata[16:9];
    assign empt = m_tdata[17];
    assign rej  = m_tdata[18];

    // A refused tap makes no edit
    `MKTE_ASSERT_IMP(a_reject_no_edit, aclk, aresetn, m_tvalid && rej,
        (op == OP_NONE) && (ch == 7'd0) && !empt)

    // Emptied text only comes from a delete down to zero length
    `MKTE_ASSERT_IMP(a_empty_on_delete, aclk, aresetn, m_tvalid && empt,
        (op == OP_DELETE) && (len == 8'd0) && !rej)

    // An append always leaves at least one character and carries one
    `MKTE_ASSERT_IMP(a_append_len, aclk, aresetn, m_tvalid && (op == OP_APPEND),
        (len != 8'd0) && (ch != 7'd0))

    // A stalled result holds
    `MKTE_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind multitap_keypad_text_entry mkte_checker u_mkte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
